@@ hw/rtl/skq_pkg.sv @@
// ----------------------------------------------------------------------------
// skq_pkg
// Shared types and constants for the sorted key queue: depth, field widths,
// command and status codes, and the control structs between the controller
// and the top level.
// ----------------------------------------------------------------------------
package skq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 16;
    localparam int PAY_W   = 32;
    localparam int ENTRY_W = 5;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [PAY_W-1:0]        pay_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [CNT_W-1:0]        cnt_t;

    localparam key_t EMPTY_KEY = key_t'(10);
    localparam key_t KEY_MIN   = key_t'(-32768);
    localparam key_t KEY_MAX   = key_t'(32767);

    typedef enum logic [2:0] {
        CMD_PREPEND  = 3'd0,
        CMD_APPEND   = 3'd1,
        CMD_INSERT   = 3'd2,
        CMD_REM_HEAD = 3'd3,
        CMD_REM_KEY  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        idx_t rd_addr;
        logic we;
        idx_t wr_addr;
        key_t wr_key;
        pay_t wr_pay;
    } ram_req_t;

    typedef struct packed {
        status_t            status;
        key_t               key;
        pay_t               pay;
        logic [ENTRY_W-1:0] count;
    } result_t;

endpackage

@@ hw/rtl/skq_ram.sv @@
// ----------------------------------------------------------------------------
// skq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data, valid in the cycle after the read address.
// ----------------------------------------------------------------------------
module skq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hw/rtl/skq_ctrl.sv @@
// ----------------------------------------------------------------------------
// skq_ctrl
// Command sequencer: scans the key memory for the position, shifts entries
// up or down one at a time, writes the new entry and builds the result.
// ----------------------------------------------------------------------------
module skq_ctrl
    import skq_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  cmd_t     in_cmd,
    input  pay_t     in_pay,
    input  key_t     in_key,
    output ram_req_t ram_req,
    input  key_t     rd_key,
    input  pay_t     rd_pay,
    output logic     res_valid,
    input  logic     res_ready,
    output result_t  res
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_WRITE,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    cmd_t    cmd_reg, cmd_next;
    pay_t    pay_reg, pay_next;
    key_t    key_reg, key_next;
    cnt_t    occ_reg, occ_next;
    idx_t    ptr_reg, ptr_next;
    idx_t    pos_reg, pos_next;
    key_t    rkey_reg, rkey_next;
    pay_t    rpay_reg, rpay_next;
    status_t status_reg, status_next;

    cnt_t ptr_inc;
    cnt_t ptr_inc2;
    idx_t ptr_dec;

    assign ptr_inc  = cnt_t'(ptr_reg) + cnt_t'(1);
    assign ptr_inc2 = ptr_inc + cnt_t'(1);
    assign ptr_dec  = ptr_reg - idx_t'(1);

    always_comb begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        pay_next    = pay_reg;
        key_next    = key_reg;
        occ_next    = occ_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        rkey_next   = rkey_reg;
        rpay_next   = rpay_reg;
        status_next = status_reg;

        ram_req.rd_addr = ptr_reg;
        ram_req.we      = 1'b0;
        ram_req.wr_addr = pos_reg;
        ram_req.wr_key  = rkey_reg;
        ram_req.wr_pay  = pay_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd_next    = in_cmd;
                    pay_next    = in_pay;
                    key_next    = in_key;
                    rkey_next   = '0;
                    rpay_next   = '0;
                    status_next = ST_OK;
                    ptr_next    = '0;
                    pos_next    = '0;
                    case (in_cmd)
                        CMD_PREPEND, CMD_APPEND, CMD_INSERT: begin
                            if (occ_reg == cnt_t'(DEPTH)) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else if (occ_reg == '0) begin
                                rkey_next  = (in_cmd == CMD_INSERT) ? in_key : EMPTY_KEY;
                                state_next = S_WRITE;
                            end else begin
                                if (in_cmd == CMD_APPEND) begin
                                    ptr_next = idx_t'(occ_reg - cnt_t'(1));
                                end
                                state_next = S_READ;
                            end
                        end
                        CMD_REM_HEAD, CMD_REM_KEY: begin
                            if (occ_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                case (cmd_reg)
                    CMD_PREPEND: begin
                        rkey_next  = (rd_key == KEY_MIN) ? KEY_MIN : rd_key - key_t'(1);
                        pos_next   = '0;
                        ptr_next   = idx_t'(occ_reg);
                        state_next = S_UP_RD;
                    end
                    CMD_APPEND: begin
                        rkey_next  = (rd_key == KEY_MAX) ? KEY_MAX : rd_key + key_t'(1);
                        pos_next   = idx_t'(occ_reg);
                        state_next = S_WRITE;
                    end
                    CMD_INSERT: begin
                        rkey_next = key_reg;
                        if (rd_key >= key_reg) begin
                            pos_next   = ptr_reg;
                            ptr_next   = idx_t'(occ_reg);
                            state_next = S_UP_RD;
                        end else if (ptr_inc == occ_reg) begin
                            pos_next   = idx_t'(occ_reg);
                            state_next = S_WRITE;
                        end else begin
                            ptr_next   = idx_t'(ptr_inc);
                            state_next = S_READ;
                        end
                    end
                    CMD_REM_HEAD, CMD_REM_KEY: begin
                        if (cmd_reg == CMD_REM_HEAD || rd_key == key_reg) begin
                            rkey_next = rd_key;
                            rpay_next = rd_pay;
                            if (ptr_inc == occ_reg) begin
                                occ_next   = occ_reg - cnt_t'(1);
                                state_next = S_DONE;
                            end else begin
                                state_next = S_DN_RD;
                            end
                        end else if (ptr_inc == occ_reg) begin
                            status_next = ST_NOT_FOUND;
                            state_next  = S_DONE;
                        end else begin
                            ptr_next   = idx_t'(ptr_inc);
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_UP_RD: begin
                ram_req.rd_addr = ptr_dec;
                state_next      = S_UP_WR;
            end
            S_UP_WR: begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = ptr_reg;
                ram_req.wr_key  = rd_key;
                ram_req.wr_pay  = rd_pay;
                ptr_next        = ptr_dec;
                state_next      = (ptr_dec == pos_reg) ? S_WRITE : S_UP_RD;
            end
            S_DN_RD: begin
                ram_req.rd_addr = idx_t'(ptr_inc);
                state_next      = S_DN_WR;
            end
            S_DN_WR: begin
                ram_req.we      = 1'b1;
                ram_req.wr_addr = ptr_reg;
                ram_req.wr_key  = rd_key;
                ram_req.wr_pay  = rd_pay;
                ptr_next        = idx_t'(ptr_inc);
                if (ptr_inc2 == occ_reg) begin
                    occ_next   = occ_reg - cnt_t'(1);
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_RD;
                end
            end
            S_WRITE: begin
                ram_req.we = 1'b1;
                occ_next   = occ_reg + cnt_t'(1);
                state_next = S_DONE;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
        cmd_reg    <= cmd_next;
        pay_reg    <= pay_next;
        key_reg    <= key_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        rkey_reg   <= rkey_next;
        rpay_reg   <= rpay_next;
        status_reg <= status_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status = status_reg;
    assign res.key    = rkey_reg;
    assign res.pay    = rpay_reg;
    assign res.count  = ENTRY_W'(occ_reg);

endmodule

@@ hw/rtl/sorted_key_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_key_queue
// Queue of key and payload entries kept in ascending key order in two
// memories, with head, tail, sorted insert and remove commands.
//
//   channel  dir  ports                    word
//   s_       in   tvalid tready tdata tuser command, payload, key
//   m_       out  tvalid tready tdata tuser status, key, payload, count
//
// one word at a time: entries are scanned and shifted one by one through
// the single read port of the key and payload memories.
// reset returns to idle and clears the occupancy and output valid only; no memory clearing pass.
// a new word is taken while the previous result waits in the output register.
// ----------------------------------------------------------------------------
module sorted_key_queue
    import skq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // payload[31:0], key[47:32]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_key[15:0], out_payload[47:16], entry_count[52:48]
    output logic [1:0]  m_tuser    // status[1:0]
);

    ram_req_t ram_req;
    key_t     rd_key;
    pay_t     rd_pay;
    logic     res_valid;
    logic     res_ready;
    result_t  res;

    logic    out_valid_reg;
    result_t out_reg;

    skq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.wr_addr),
        .wdata (ram_req.wr_key),
        .raddr (ram_req.rd_addr),
        .rdata (rd_key)
    );

    skq_ram #(
        .WIDTH(PAY_W),
        .DEPTH(DEPTH)
    ) u_pay_ram (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.wr_addr),
        .wdata (ram_req.wr_pay),
        .raddr (ram_req.rd_addr),
        .rdata (rd_pay)
    );

    skq_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (cmd_t'(s_tuser)),
        .in_pay    (s_tdata[31:0]),
        .in_key    (s_tdata[47:32]),
        .ram_req   (ram_req),
        .rd_key    (rd_key),
        .rd_pay    (rd_pay),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {3'b000, out_reg.count, out_reg.pay, out_reg.key};

endmodule
